[rtl/cmg_pkg.sv]
`timescale 1ns / 1ps

package cmg_pkg;

    localparam int unsigned GRID_COLS = 7;

    localparam logic [5:0]  CELL_LAST = 6'd41;
    localparam logic [13:0] YEAR_MIN  = 14'd1;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_MAR = 4'd3;
    localparam logic [2:0]  WD_SEVEN  = 3'd7;
    localparam logic [2:0]  WD_RESET  = 3'd1;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 10000
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;

    typedef struct packed {
        logic [2:0] lead;   // blank cells before day one
        logic [4:0] dim;    // days in month
        logic [2:0] wd;     // weekday of day one
    } t_month_info;

    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd2:    r = 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

[rtl/cmg_dow.sv]
`timescale 1ns / 1ps

module cmg_dow (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [13:0]          i_year,
    input  logic [3:0]           i_month,
    input  logic [2:0]           i_first_wd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cmg_pkg::t_month_info o_info
);
    import cmg_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // stage 1: clamped year and month
    logic [13:0] r_y1, n_y1;
    logic [3:0]  r_m1, n_m1;
    // stage 2: year / 100
    logic [13:0] r_y2;
    logic [3:0]  r_m2;
    logic [6:0]  r_q2;
    logic [26:0] w_prod;
    // stage 3: shifted year for Jan/Feb, leap flag
    logic [13:0] r_yy3, n_yy3;
    logic [6:0]  r_qy3, n_qy3;
    logic [3:0]  r_m3;
    logic        r_leap3, n_leap3;
    logic [13:0] w_r100;
    logic        w_early;
    // stage 4: Sakamoto sum and month length
    logic [14:0] r_s4, n_s4;
    logic [4:0]  r_dim4, n_dim4;
    // stage 5: mod 7 and lead
    t_month_info r_info5, n_info5;
    logic [5:0]  w_f1;
    logic [3:0]  w_f2;
    logic [2:0]  w_wd;
    logic [3:0]  w_t;

    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v5;
    assign o_info  = r_info5;

    always_comb begin
        n_y1 = i_year;
        if (i_year < YEAR_MIN) begin
            n_y1 = YEAR_MIN;
        end else if (i_year > YEAR_MAX) begin
            n_y1 = YEAR_MAX;
        end
        n_m1 = i_month;
        if (i_month < MONTH_MIN) begin
            n_m1 = MONTH_MIN;
        end else if (i_month > MONTH_MAX) begin
            n_m1 = MONTH_MAX;
        end
    end

    assign w_prod = 27'(r_y1) * 27'(DIV100_MUL);

    always_comb begin
        w_r100  = r_y2 - (14'(r_q2) * 14'd100);
        w_early = r_m2 < MONTH_MAR;
        n_yy3   = r_y2 - 14'(w_early);
        // stepping back a year crosses a century boundary only when y % 100 is 0
        n_qy3   = (w_early && w_r100 == 14'd0) ? r_q2 - 7'd1 : r_q2;
        n_leap3 = (r_y2[1:0] == 2'd0 && w_r100 != 14'd0)
               || (w_r100 == 14'd0 && r_q2[1:0] == 2'd0);
    end

    always_comb begin
        n_s4 = 15'(r_yy3) + 15'(r_yy3[13:2]) - 15'(r_qy3) + 15'(r_qy3[6:2])
             + 15'(month_offset(r_m3)) + 15'd1;
        n_dim4 = (r_m3 == MONTH_FEB && r_leap3) ? 5'd29 : month_days(r_m3);
    end

    // 8 = 1 mod 7: fold octal digits
    always_comb begin
        w_f1 = 6'(r_s4[2:0]) + 6'(r_s4[5:3]) + 6'(r_s4[8:6])
             + 6'(r_s4[11:9]) + 6'(r_s4[14:12]);
        w_f2 = 4'(w_f1[2:0]) + 4'(w_f1[5:3]);
        w_wd = (w_f2 >= 4'(GRID_COLS)) ? 3'(w_f2 - 4'(GRID_COLS)) : w_f2[2:0];
        w_t  = 4'(w_wd) + 4'(GRID_COLS) - 4'(i_first_wd);
        n_info5.wd   = w_wd;
        n_info5.dim  = r_dim4;
        n_info5.lead = (w_t >= 4'(GRID_COLS)) ? 3'(w_t - 4'(GRID_COLS)) : w_t[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_y1 <= n_y1;
            r_m1 <= n_m1;
        end
        if (en2) begin
            r_y2 <= r_y1;
            r_m2 <= r_m1;
            r_q2 <= w_prod[DIV100_SHIFT +: 7];
        end
        if (en3) begin
            r_yy3   <= n_yy3;
            r_qy3   <= n_qy3;
            r_m3    <= r_m2;
            r_leap3 <= n_leap3;
        end
        if (en4) begin
            r_s4   <= n_s4;
            r_dim4 <= n_dim4;
        end
        if (en5) begin
            r_info5 <= n_info5;
        end
    end

endmodule

[rtl/calendar_month_grid.sv]
`timescale 1ns / 1ps
// Path: an accepted word passes the five date stages, then the cell counter, and its
// cells leave through the output register.
// Throughput: one cell per cycle while the output is not stalled, 42 cells per word;
// the date pipeline takes the next word while the current grid streams out.
// Reset: synchronous active low; clears all valid bits and sets first weekday to 1.
module calendar_month_grid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // year[13:0], month[17:14], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_index[5:0], day_number[10:6], month_length[15:11], first_day_weekday[18:16]
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast   // last_cell
);
    import cmg_pkg::*;

    logic [2:0]  r_fwd;
    logic        dow_valid;
    t_month_info dow_info;

    logic        r_gv;
    logic [5:0]  r_cnt;
    t_month_info r_info;
    logic        gen_ready;
    logic        out_load;
    logic [6:0]  w_diff;
    logic [4:0]  n_day;

    logic        r_ov;
    logic [5:0]  r_ocell;
    logic [4:0]  r_oday;
    logic [4:0]  r_odim;
    logic [2:0]  r_owd;
    logic        r_olast;

    // weekday 7 is taken as Sunday
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= WD_RESET;
        end else if (i_cfg_wr_en) begin
            r_fwd <= (i_cfg_wr_data == WD_SEVEN) ? 3'd0 : i_cfg_wr_data;
        end
    end

    cmg_dow u_dow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_year     (i_s_tdata[13:0]),
        .i_month    (i_s_tdata[17:14]),
        .i_first_wd (r_fwd),
        .o_valid    (dow_valid),
        .i_ready    (gen_ready),
        .o_info     (dow_info)
    );

    assign out_load  = r_gv && (!r_ov || i_m_tready);
    // next month is taken in the cycle its predecessor's last cell is loaded into the output register
    assign gen_ready = !r_gv || (out_load && r_cnt == CELL_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv  <= 1'b0;
            r_cnt <= 6'd0;
        end else if (gen_ready) begin
            r_gv  <= dow_valid;
            r_cnt <= 6'd0;
        end else if (out_load) begin
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_ready && dow_valid) begin
            r_info <= dow_info;
        end
    end

    always_comb begin
        w_diff = 7'(r_cnt) - 7'(r_info.lead);
        n_day  = 5'd0;
        if (r_cnt >= 6'(r_info.lead) && w_diff < 7'(r_info.dim)) begin
            n_day = 5'(w_diff + 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ocell <= r_cnt;
            r_oday  <= n_day;
            r_odim  <= r_info.dim;
            r_owd   <= r_info.wd;
            r_olast <= (r_cnt == CELL_LAST);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'd0, r_owd, r_odim, r_oday, r_ocell};
    assign o_m_tlast  = r_olast;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gv |-> r_cnt <= CELL_LAST)
        else $error("cell counter beyond grid");

    a_cell_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && o_m_tdata[5:0] == $past(o_m_tdata[5:0]) + 6'd1)
        else $error("grid run broken before last cell");

    a_day_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[10:6] <= o_m_tdata[15:11])
        else $error("day number past month length");

endmodule
